@@ rtl/core/bba_pkg.sv @@
// Shared types and codes of the bitmap block allocator.
`default_nettype none

package bba_pkg;

   // Default size of the block map.
   localparam int NUM_BLOCKS_DEF = 16384;

   // Command codes.
   localparam logic [1:0] CMD_ALLOC = 2'd0;
   localparam logic [1:0] CMD_FREE  = 2'd1;
   localparam logic [1:0] CMD_FIND  = 2'd2;

   // Status codes.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_CLIPPED   = 2'd2;

   // Request beat.
   typedef struct packed {
      logic [1:0]  cmd;
      logic [13:0] start_index;
      logic [14:0] block_count;
   } req_type;

   // Response beat.
   typedef struct packed {
      logic [13:0] found_start;
      logic [1:0]  status;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/core/bitmap_block_allocator.sv @@
// Bitmap first-fit block allocator: free-space map, run marking and first-fit search.
//
// One request beat carries a command, a start block and a block count; every
// request yields exactly one response beat with a found start and a status.
// Allocate sets the used bits of a run, free clears them, and find scans from
// block 0 for the lowest run of free blocks of the requested length. Runs that
// pass the end of the map are clipped and report the clipped status.
// The map lives in one memory of 32-bit words with a single read and a single
// write port; the sequencer streams one word per cycle through it, writing
// back the previous word while the next is read.
// A command reads and writes back only the words that its run touches; find scans
// from word 0 and ends early at the first fit. Commands that need no map access
// go straight to the done state. A new request is accepted only in the idle
// state.
// After reset the block runs a clearing pass over all MAP_WORDS words (512 at the
// default size) with req_stall high, then the whole map reads as free.
// A response waits in its output register while rsp_stall is high; the next
// request may still be accepted and worked on, and its result is held back
// until the register is free.
`default_nettype none

module bitmap_block_allocator #(
   parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire bba_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output bba_pkg::rsp_type      rsp_data
);

   import bba_pkg::*;

   localparam int MAP_WORDS = (NUM_BLOCKS + 31) / 32;
   localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int CW        = ($clog2(NUM_BLOCKS + 1) > 15) ? $clog2(NUM_BLOCKS + 1) : 15;
   localparam int BW        = CW + 1;
   localparam int LAST_BITS = NUM_BLOCKS - (MAP_WORDS - 1) * 32;
   localparam logic [31:0]    LAST_MASK = 32'hFFFF_FFFF >> (32 - LAST_BITS);
   localparam logic [AW-1:0]  LAST_WORD = AW'(MAP_WORDS - 1);
   localparam logic [BW-1:0]  NUM_B     = BW'(NUM_BLOCKS);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   // Map memory and its read register.
   logic [31:0] block_used_map [MAP_WORDS];
   logic [31:0] map_rd_ff;

   // Sequencer state.
   state_type   state_ff, state_in;
   logic [1:0]  cmd_ff, cmd_in;
   logic [BW-1:0] len_ff, len_in;
   logic [BW-1:0] run_ff, run_in;
   logic [AW-1:0] rd_addr_ff, rd_addr_in;
   logic          rd_more_ff, rd_more_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] pend_addr_ff, pend_addr_in;
   logic [AW-1:0] first_word_ff, first_word_in;
   logic [AW-1:0] end_word_ff, end_word_in;
   logic [4:0]    first_lo_ff, first_lo_in;
   logic [4:0]    last_lo_ff, last_lo_in;
   logic [13:0]   res_start_ff, res_start_in;
   logic [1:0]    res_status_ff, res_status_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   // Memory port controls.
   logic          rd_en;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [31:0]   wr_data;

   // Request decode.
   logic [BW-1:0] req_first;
   logic [BW-1:0] req_len;
   logic [BW-1:0] req_end;
   logic [BW-1:0] req_last;
   logic [BW-1:0] req_last_m1;

   assign req_first   = BW'(req_data.start_index);
   assign req_len     = BW'(req_data.block_count);
   assign req_end     = req_first + req_len;
   assign req_last    = (req_end > NUM_B) ? NUM_B : req_end;
   assign req_last_m1 = req_last - BW'(1);

   // Mask of the blocks in the pending word that the run covers.
   logic [4:0]  mark_lo;
   logic [4:0]  mark_hi;
   logic [31:0] mark_mask;
   logic [31:0] mark_word;

   assign mark_lo   = (pend_addr_ff == first_word_ff) ? first_lo_ff : 5'd0;
   assign mark_hi   = (pend_addr_ff == end_word_ff) ? last_lo_ff : 5'd31;
   assign mark_mask = (32'hFFFF_FFFF << mark_lo) & (32'hFFFF_FFFF >> (5'd31 - mark_hi));
   assign mark_word = (cmd_ff == CMD_ALLOC) ? (map_rd_ff | mark_mask)
                                            : (map_rd_ff & ~mark_mask);

   // First-fit step over one word: free run ending at each bit by prefix doubling.
   logic [31:0]   free_bits;
   logic [5:0]    lv [6][32];
   logic [BW-1:0] tot [32];
   logic [31:0]   hit;
   logic [4:0]    hit_idx;
   logic          any_hit;
   logic [BW-1:0] word_base;
   logic [BW-1:0] found_pos;
   logic [BW-1:0] run_next;

   assign free_bits = ~map_rd_ff & ((pend_addr_ff == LAST_WORD) ? LAST_MASK : 32'hFFFF_FFFF);
   assign word_base = BW'({pend_addr_ff, 5'd0});

   always_comb begin
      for (int b = 0; b < 32; b++) begin
         lv[0][b] = {5'd0, free_bits[b]};
      end
      for (int l = 0; l < 5; l++) begin
         for (int b = 0; b < 32; b++) begin
            if ((b >= (1 << l)) && (lv[l][b] == 6'(1 << l))) begin
               lv[l+1][b] = lv[l][b] + lv[l][b - (1 << l)];
            end else begin
               lv[l+1][b] = lv[l][b];
            end
         end
      end
      for (int b = 0; b < 32; b++) begin
         if (lv[5][b] == 6'(b + 1)) begin
            tot[b] = run_ff + BW'(b + 1);
         end else begin
            tot[b] = BW'(lv[5][b]);
         end
         hit[b] = (tot[b] >= len_ff);
      end
      hit_idx = 5'd0;
      for (int b = 31; b >= 0; b--) begin
         if (hit[b]) begin
            hit_idx = 5'(b);
         end
      end
   end

   assign any_hit   = |hit;
   assign found_pos = word_base + BW'(hit_idx) + BW'(1) - len_ff;
   assign run_next  = (lv[5][31] == 6'd32) ? (run_ff + BW'(32)) : BW'(lv[5][31]);

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      len_in        = len_ff;
      run_in        = run_ff;
      rd_addr_in    = rd_addr_ff;
      rd_more_in    = rd_more_ff;
      pend_in       = pend_ff;
      pend_addr_in  = pend_addr_ff;
      first_word_in = first_word_ff;
      end_word_in   = end_word_ff;
      first_lo_in   = first_lo_ff;
      last_lo_in    = last_lo_ff;
      res_start_in  = res_start_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = pend_addr_ff;
      wr_data       = mark_word;

      // The response register empties when its beat is taken.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = rd_addr_ff;
            wr_data    = 32'd0;
            rd_addr_in = rd_addr_ff + AW'(1);
            if (rd_addr_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in        = req_data.cmd;
               len_in        = req_len;
               run_in        = '0;
               pend_in       = 1'b0;
               rd_more_in    = 1'b1;
               res_start_in  = 14'd0;
               res_status_in = STATUS_OK;
               state_in      = ST_DONE;
               case (req_data.cmd)
                  CMD_ALLOC, CMD_FREE: begin
                     if (req_len == '0) begin
                        res_status_in = STATUS_OK;
                     end else if (req_first >= NUM_B) begin
                        res_status_in = STATUS_CLIPPED;
                     end else begin
                        res_status_in = (req_end > NUM_B) ? STATUS_CLIPPED : STATUS_OK;
                        rd_addr_in    = AW'(req_first >> 5);
                        first_word_in = AW'(req_first >> 5);
                        end_word_in   = AW'(req_last_m1 >> 5);
                        first_lo_in   = req_first[4:0];
                        last_lo_in    = req_last_m1[4:0];
                        state_in      = ST_SCAN;
                     end
                  end
                  CMD_FIND: begin
                     if ((req_len == '0) || (req_len > NUM_B)) begin
                        res_status_in = STATUS_NOT_FOUND;
                     end else begin
                        rd_addr_in    = '0;
                        first_word_in = '0;
                        end_word_in   = LAST_WORD;
                        state_in      = ST_SCAN;
                     end
                  end
                  default: begin
                     res_status_in = STATUS_NOT_FOUND;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // Read the next word while the previous one is worked on.
            if (rd_more_ff) begin
               rd_en        = 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = rd_addr_ff;
               rd_addr_in   = rd_addr_ff + AW'(1);
               rd_more_in   = (rd_addr_ff != end_word_ff);
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               if (cmd_ff == CMD_FIND) begin
                  run_in = run_next;
                  if (any_hit) begin
                     res_start_in  = found_pos[13:0];
                     res_status_in = STATUS_OK;
                     state_in      = ST_DONE;
                  end else if (pend_addr_ff == end_word_ff) begin
                     res_status_in = STATUS_NOT_FOUND;
                     state_in      = ST_DONE;
                  end
               end else begin
                  wr_en = 1'b1;
                  if (pend_addr_ff == end_word_ff) begin
                     state_in = ST_DONE;
                  end
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.found_start = res_start_ff;
               rsp_data_in.status      = res_status_ff;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Map memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         block_used_map[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         map_rd_ff <= block_used_map[rd_addr_ff];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rd_addr_ff   <= '0;
         rd_more_ff   <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_addr_ff   <= rd_addr_in;
         rd_more_ff   <= rd_more_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      len_ff        <= len_in;
      run_ff        <= run_in;
      pend_addr_ff  <= pend_addr_in;
      first_word_ff <= first_word_in;
      end_word_ff   <= end_word_in;
      first_lo_ff   <= first_lo_in;
      last_lo_ff    <= last_lo_in;
      res_start_ff  <= res_start_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // No response may appear before the clearing pass has finished.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid_ff)
      else $error("response during clearing pass");

   // An accepted request always takes the sequencer out of idle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("sequencer stayed idle after a request beat");

   // Map writes stay inside the memory.
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (wr_addr <= LAST_WORD))
      else $error("map write beyond the last word");

   // During a search the carried free run never reaches the requested length.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && (cmd_ff == CMD_FIND)) |-> (run_ff < len_ff))
      else $error("search missed a fitting run");

   // A response never carries the unused status code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_data_ff.status == STATUS_OK) ||
                        (rsp_data_ff.status == STATUS_NOT_FOUND) ||
                        (rsp_data_ff.status == STATUS_CLIPPED)))
      else $error("response with an unused status");

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench of the bitmap block allocator: directed beats, then random traffic.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bba_pkg::*;

   localparam int NUM_BLOCKS = NUM_BLOCKS_DEF;
   // The one command code that the package leaves unused.
   localparam logic [1:0] CMD_SPARE = 2'd3;
   localparam int DIR_ROWS = 25;
   localparam int RANDOM_ITEMS = 1145;
   localparam int LONG_HOLDOFF = 3000;
   localparam int HOLDOFF_AFTER = 300;
   localparam int DRAIN_CYCLES = 520;
   localparam int LIMIT_CYCLES = 2_600_000;
   localparam int REPORT_MAX = 10;
   // Whether a directed row carries its reply written out, or takes it from the mirror.
   localparam logic KNOWN = 1'b1;
   localparam logic DERIVED = 1'b0;

   typedef struct packed {
      req_type beat;
      logic    known;
      rsp_type reply;
   } plan_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Mirror of the used-block map; all blocks are free after reset.
   bit [NUM_BLOCKS-1:0] shadow_used;
   rsp_type             due_replies [$];
   int                  mismatches = 0;
   int                  replies_seen = 0;
   int                  cycle_count = 0;
   bit                  req_calm = 1'b0;

   // Directed beats: extremes of every field, every command and each corner of the map.
   plan_row_type plan [DIR_ROWS] = '{
      {CMD_FIND,  14'd0,     15'd1,     KNOWN,   14'd0, STATUS_OK},
      {CMD_FIND,  14'd0,     15'd16384, KNOWN,   14'd0, STATUS_OK},
      {CMD_FIND,  14'd0,     15'd0,     KNOWN,   14'd0, STATUS_NOT_FOUND},
      {CMD_FIND,  14'd0,     15'd16385, KNOWN,   14'd0, STATUS_NOT_FOUND},
      {CMD_FIND,  14'd16383, 15'd32767, KNOWN,   14'd0, STATUS_NOT_FOUND},
      {CMD_ALLOC, 14'd0,     15'd0,     KNOWN,   14'd0, STATUS_OK},
      {CMD_ALLOC, 14'd16383, 15'd1,     KNOWN,   14'd0, STATUS_OK},
      {CMD_ALLOC, 14'd16383, 15'd2,     KNOWN,   14'd0, STATUS_CLIPPED},
      {CMD_ALLOC, 14'd16000, 15'd32767, KNOWN,   14'd0, STATUS_CLIPPED},
      {CMD_FIND,  14'd0,     15'd16384, KNOWN,   14'd0, STATUS_NOT_FOUND},
      {CMD_FIND,  14'd0,     15'd16000, KNOWN,   14'd0, STATUS_OK},
      {CMD_FIND,  14'd0,     15'd16001, KNOWN,   14'd0, STATUS_NOT_FOUND},
      {CMD_FREE,  14'd0,     15'd16384, KNOWN,   14'd0, STATUS_OK},
      {CMD_SPARE, 14'd16383, 15'd32767, KNOWN,   14'd0, STATUS_NOT_FOUND},
      {CMD_ALLOC, 14'd0,     15'd10,    KNOWN,   14'd0, STATUS_OK},
      {CMD_FIND,  14'd0,     15'd5,     DERIVED, 14'd0, STATUS_OK},
      {CMD_ALLOC, 14'd12,    15'd3,     KNOWN,   14'd0, STATUS_OK},
      {CMD_FIND,  14'd0,     15'd3,     DERIVED, 14'd0, STATUS_OK},
      {CMD_FIND,  14'd0,     15'd2,     DERIVED, 14'd0, STATUS_OK},
      {CMD_FREE,  14'd16383, 15'd0,     KNOWN,   14'd0, STATUS_OK},
      {CMD_FREE,  14'd16380, 15'd5,     KNOWN,   14'd0, STATUS_CLIPPED},
      {CMD_ALLOC, 14'd8191,  15'd8193,  KNOWN,   14'd0, STATUS_OK},
      {CMD_FIND,  14'd0,     15'd8176,  DERIVED, 14'd0, STATUS_OK},
      {CMD_FIND,  14'd0,     15'd8177,  DERIVED, 14'd0, STATUS_OK},
      {CMD_FREE,  14'd0,     15'd16384, KNOWN,   14'd0, STATUS_OK}
   };

   bitmap_block_allocator #(
      .NUM_BLOCKS(NUM_BLOCKS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Applies one command to the mirrored map and returns the reply it must produce.
   function automatic rsp_type apply_block_command(input req_type beat);
      rsp_type     reply;
      int unsigned first;
      int unsigned len;
      int unsigned last;
      int unsigned run;
      int unsigned b;
      bit          hit;
      reply.found_start = '0;
      reply.status = STATUS_OK;
      first = beat.start_index;
      len = beat.block_count;
      case (beat.cmd)
         CMD_ALLOC, CMD_FREE: begin
            if (len != 0) begin
               if (first >= NUM_BLOCKS) begin
                  reply.status = STATUS_CLIPPED;
               end else begin
                  last = first + len;
                  if (last > NUM_BLOCKS) begin
                     last = NUM_BLOCKS;
                     reply.status = STATUS_CLIPPED;
                  end
                  for (b = first; b < last; b++) shadow_used[b] = (beat.cmd == CMD_ALLOC);
               end
            end
         end
         CMD_FIND: begin
            // First fit: lowest run of free blocks of the asked length.
            reply.status = STATUS_NOT_FOUND;
            if (len != 0 && len <= NUM_BLOCKS) begin
               run = 0;
               hit = 1'b0;
               b = 0;
               while (!hit && b < NUM_BLOCKS) begin
                  if (shadow_used[b]) run = 0;
                  else run++;
                  if (run == len) begin
                     hit = 1'b1;
                     reply.found_start = 14'(b + 1 - len);
                     reply.status = STATUS_OK;
                  end
                  b++;
               end
            end
         end
         default: begin
            reply.status = STATUS_NOT_FOUND;
         end
      endcase
      return reply;
   endfunction

   function automatic int pick_wait(input bit calm);
      if (calm) return 0;
      return $urandom_range(0, 10);
   endfunction

   // Offers one request beat after a random gap and records its reply once it is taken.
   task automatic send_beat(input req_type beat, input logic known, input rsp_type typed_reply,
                            output rsp_type predicted);
      int gap;
      gap = pick_wait(req_calm);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = apply_block_command(beat);
      due_replies.push_back(known ? typed_reply : predicted);
   endtask

   // Request side: directed rows first, then random commands.
   initial begin : request_side
      int          n;
      int          roll;
      req_type     beat;
      rsp_type     outcome;
      bit          chain;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      for (n = 0; n < DIR_ROWS; n++) begin
         send_beat(plan[n].beat, plan[n].known, plan[n].reply, outcome);
      end
      chain = 1'b0;
      beat = '0;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 50 == 0) req_calm = ($urandom_range(0, 9) < 3);
         if (chain) begin
            // Claim the run that the last search found, as a real allocator would.
            beat.cmd = CMD_ALLOC;
            beat.start_index = outcome.found_start;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 35) beat.cmd = CMD_ALLOC;
            else if (roll < 70) beat.cmd = CMD_FREE;
            else if (roll < 98) beat.cmd = CMD_FIND;
            else beat.cmd = CMD_SPARE;
            // Most runs land low in the map so that it fragments and searches work hard.
            roll = $urandom_range(0, 99);
            if (roll < 70) beat.start_index = 14'($urandom_range(0, 1023));
            else if (roll < 90) beat.start_index = 14'($urandom_range(0, NUM_BLOCKS - 1));
            else beat.start_index = 14'($urandom_range(NUM_BLOCKS - 128, NUM_BLOCKS - 1));
            // Long runs are slow, so only a few beats carry them.
            roll = $urandom_range(0, 99);
            if (roll < 75) beat.block_count = 15'($urandom_range(0, 48));
            else if (roll < 93) beat.block_count = 15'($urandom_range(49, 1024));
            else if (roll < 98) beat.block_count = 15'($urandom_range(1025, NUM_BLOCKS));
            else beat.block_count = 15'($urandom_range(NUM_BLOCKS + 1, 32767));
         end
         send_beat(beat, DERIVED, '0, outcome);
         chain = !chain && beat.cmd == CMD_FIND && outcome.status == STATUS_OK
                 && $urandom_range(0, 9) < 6;
      end
      req_valid <= 1'b0;
      while (due_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Reply side: random stall before each beat, and one long hold-off so the block backs up.
   initial begin : reply_side
      int hold;
      int served;
      bit rsp_calm;
      bit holdoff_done;
      served = 0;
      rsp_calm = 1'b0;
      holdoff_done = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (served % 50 == 0) rsp_calm = ($urandom_range(0, 9) < 3);
         hold = pick_wait(rsp_calm);
         if (!holdoff_done && replies_seen >= HOLDOFF_AFTER) begin
            hold = LONG_HOLDOFF;
            holdoff_done = 1'b1;
         end
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         served++;
      end
   end

   // Each reply beat taken is compared with the oldest outstanding expectation.
   always @(posedge clock) begin : reply_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         replies_seen++;
         if (due_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("reply %0d arrived with nothing outstanding: start %0d status %0d",
                        replies_seen, rsp_data.found_start, rsp_data.status);
         end else begin
            want = due_replies.pop_front();
            if (rsp_data.found_start !== want.found_start
                || rsp_data.status !== want.status) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("reply %0d: expected start %0d status %0d, got start %0d status %0d",
                           replies_seen, want.found_start, want.status,
                           rsp_data.found_start, rsp_data.status);
            end
         end
      end
   end

   // Guard against a hang; the bound covers the clearing pass and the slowest legal run.
   initial begin : watchdog
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/bba_pkg.sv
rtl/core/bitmap_block_allocator.sv
dv/tb_top.sv
